>>> design/three_rotor_substitution_cipher_top_assert.svh
// Assertion macros shared by the rotor cipher modules.
`ifndef THREE_ROTOR_SUBSTITUTION_CIPHER_TOP_ASSERT_SVH
`define THREE_ROTOR_SUBSTITUTION_CIPHER_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TRSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TRSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/trsc_pkg.sv
// Shared types, constants and helper functions of the rotor cipher.
`default_nettype none

package trsc_pkg;

    localparam int ALPHABET    = 26;
    localparam int LETTER_BASE = 65;
    localparam int LOWER_BASE  = 97;
    localparam int NUM_TABLES  = 5;
    localparam int NUM_STAGES  = 9;
    localparam int MEM_DEPTH   = NUM_TABLES * ALPHABET;

    typedef logic [4:0] letter_t;
    typedef logic [7:0] byte_t;
    typedef logic [7:0] maddr_t;
    typedef logic [3:0] stage_t;

    // Input transaction opcodes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_CHAR    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_DIRECTION    = 2'd0;
    localparam logic [1:0] REG_START_FAST   = 2'd1;
    localparam logic [1:0] REG_START_MIDDLE = 2'd2;
    localparam logic [1:0] REG_START_SLOW   = 2'd3;

    // Wiring table codes
    localparam logic [2:0] TBL_PLUG   = 3'd0;
    localparam logic [2:0] TBL_FAST   = 3'd1;
    localparam logic [2:0] TBL_MIDDLE = 3'd2;
    localparam logic [2:0] TBL_SLOW   = 3'd3;
    localparam logic [2:0] TBL_REFL   = 3'd4;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_RESTART,
        CMD_LETTER,
        CMD_PASS
    } cmd_kind_t;

    // One classified transaction waiting for the back end
    typedef struct packed {
        cmd_kind_t kind;
        maddr_t    addr;
        letter_t   value;
        byte_t     raw;
    } cmd_t;

    typedef struct packed {
        logic    direction;
        letter_t start_fast;
        letter_t start_middle;
        letter_t start_slow;
    } cfg_t;

    // Sum of two letter indexes, wrapped once at the alphabet size
    function automatic letter_t add_mod26(input letter_t a, input letter_t b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 6'(ALPHABET)) ? 5'(s - 6'(ALPHABET)) : 5'(s);
    endfunction

    // First memory address of a wiring table
    function automatic maddr_t tbl_base(input logic [2:0] t);
        return 8'(8'(t) * 8'(ALPHABET));
    endfunction

    // Table used by each step of the plugboard-rotors-reflector chain
    function automatic logic [2:0] stage_tbl(input stage_t s);
        logic [2:0] t;
        unique case (s)
            4'd0, 4'd8: t = TBL_PLUG;
            4'd1, 4'd7: t = TBL_FAST;
            4'd2, 4'd6: t = TBL_MIDDLE;
            4'd3, 4'd5: t = TBL_SLOW;
            default:    t = TBL_REFL;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

>>> design/trsc_front.sv
// Front end: accepts input transactions, classifies them and queues the ones it keeps.
`default_nettype none
`include "three_rotor_substitution_cipher_top_assert.svh"

module trsc_front #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      opcode,
    input  logic [2:0]      table_select,
    input  logic [4:0]      entry_index,
    input  logic [4:0]      entry_value,
    input  logic [7:0]      char_in,
    output logic            q_valid,
    output trsc_pkg::cmd_t  q_cmd,
    input  logic            q_pop
);
    import trsc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             fifo_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    cmd_t cmd_new;
    logic keep;
    logic is_lower;
    logic is_upper;
    logic push;

    // Classify the incoming transaction; drop the ones with no effect
    always_comb
    begin
        is_lower = (char_in >= 8'(LOWER_BASE)) && (char_in <= 8'(LOWER_BASE + ALPHABET - 1));
        is_upper = (char_in >= 8'(LETTER_BASE)) && (char_in <= 8'(LETTER_BASE + ALPHABET - 1));
        cmd_new.kind  = CMD_PASS;
        cmd_new.addr  = tbl_base(table_select) + maddr_t'(entry_index);
        cmd_new.value = entry_value;
        cmd_new.raw   = char_in;
        keep          = 1'b0;
        unique case (opcode)
            OP_LOAD:
            begin
                cmd_new.kind = CMD_LOAD;
                keep = (table_select < 3'(NUM_TABLES)) && (entry_index < 5'(ALPHABET))
                       && (entry_value < 5'(ALPHABET));
            end
            OP_RESTART:
            begin
                cmd_new.kind = CMD_RESTART;
                keep = 1'b1;
            end
            OP_CHAR:
            begin
                keep = 1'b1;
                if (is_lower)
                begin
                    cmd_new.kind  = CMD_LETTER;
                    cmd_new.value = 5'(char_in - 8'(LOWER_BASE));
                end
                else if (is_upper)
                begin
                    cmd_new.kind  = CMD_LETTER;
                    cmd_new.value = 5'(char_in - 8'(LETTER_BASE));
                end
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_ready = (count_reg != CNT_W'(DEPTH));
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = fifo_reg[rd_ptr_reg];

    // Advance queue pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (q_pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Hold queued transactions
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_new;
        end
    end

    `TRSC_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid, "queue popped while empty")
    `TRSC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue overfilled")

endmodule

`default_nettype wire

>>> design/trsc_back.sv
// Back end: table memory, rotor state, substitution sequencer and output register.
`default_nettype none
`include "three_rotor_substitution_cipher_top_assert.svh"

module trsc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  trsc_pkg::cfg_t  cfg,
    input  logic            q_valid,
    input  trsc_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      char_out
);
    import trsc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FWD,
        S_INV,
        S_OUT
    } state_t;

    state_t  state_reg;
    letter_t off_fast_reg;
    letter_t off_middle_reg;
    letter_t off_slow_reg;
    letter_t fast_steps_reg;
    letter_t middle_steps_reg;
    stage_t  stg_reg;
    logic    pend_reg;
    letter_t iss_reg;
    logic    chk_valid_reg;
    letter_t chk_k_reg;
    letter_t x_reg;
    byte_t   res_reg;
    logic    out_valid_reg;
    byte_t   char_out_reg;

    letter_t wiring_mem [MEM_DEPTH];
    letter_t rd_data_reg;

    letter_t stage_off;
    letter_t x_in;
    letter_t inv_x;
    maddr_t  stage_base;
    maddr_t  rd_addr;
    logic    inv_match;
    logic    inv_last;
    logic    out_free;
    logic    fast_wrap;
    logic    middle_wrap;
    logic    do_load;

    // Select the rotor offset of the current chain step
    always_comb
    begin
        unique case (stage_tbl(stg_reg))
            TBL_FAST:   stage_off = off_fast_reg;
            TBL_MIDDLE: stage_off = off_middle_reg;
            TBL_SLOW:   stage_off = off_slow_reg;
            default:    stage_off = '0;
        endcase
    end

    // Form the table read address for a forward step or an inverse probe
    always_comb
    begin
        stage_base = tbl_base(stage_tbl(stg_reg));
        x_in       = pend_reg ? rd_data_reg : x_reg;
        if (state_reg == S_INV)
        begin
            rd_addr = stage_base + maddr_t'(add_mod26(iss_reg, stage_off));
        end
        else
        begin
            rd_addr = stage_base + maddr_t'(add_mod26(x_in, stage_off));
        end
    end

    assign inv_match   = chk_valid_reg && (rd_data_reg == x_reg);
    assign inv_last    = chk_valid_reg && (chk_k_reg == 5'(ALPHABET - 1));
    assign inv_x       = inv_match ? chk_k_reg : x_reg;
    assign out_free    = !out_valid_reg || out_ready;
    assign fast_wrap   = (fast_steps_reg == 5'(ALPHABET - 1));
    assign middle_wrap = (middle_steps_reg == 5'(ALPHABET - 1));
    assign q_pop       = (state_reg == S_IDLE) && q_valid;
    assign do_load     = q_pop && (q_cmd.kind == CMD_LOAD);
    assign out_valid   = out_valid_reg;
    assign char_out    = char_out_reg;

    // Wiring table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            wiring_mem[q_cmd.addr] <= q_cmd.value;
        end
        rd_data_reg <= wiring_mem[rd_addr];
    end

    // Sequence each transaction and hold the result for the receiver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            off_fast_reg     <= '0;
            off_middle_reg   <= '0;
            off_slow_reg     <= '0;
            fast_steps_reg   <= '0;
            middle_steps_reg <= '0;
            stg_reg          <= '0;
            pend_reg         <= 1'b0;
            iss_reg          <= '0;
            chk_valid_reg    <= 1'b0;
            chk_k_reg        <= '0;
            x_reg            <= '0;
            res_reg          <= '0;
            out_valid_reg    <= 1'b0;
            char_out_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        unique case (q_cmd.kind)
                            CMD_LOAD:
                            begin
                                // table write happens in the memory block
                            end
                            CMD_RESTART:
                            begin
                                off_fast_reg     <= add_mod26(cfg.start_fast, '0);
                                off_middle_reg   <= add_mod26(cfg.start_middle, '0);
                                off_slow_reg     <= add_mod26(cfg.start_slow, '0);
                                fast_steps_reg   <= '0;
                                middle_steps_reg <= '0;
                            end
                            CMD_LETTER:
                            begin
                                // step the rotors like an odometer
                                off_fast_reg <= add_mod26(off_fast_reg, 5'd1);
                                if (fast_wrap)
                                begin
                                    fast_steps_reg <= '0;
                                    off_middle_reg <= add_mod26(off_middle_reg, 5'd1);
                                    if (middle_wrap)
                                    begin
                                        middle_steps_reg <= '0;
                                        off_slow_reg     <= add_mod26(off_slow_reg, 5'd1);
                                    end
                                    else
                                    begin
                                        middle_steps_reg <= middle_steps_reg + 5'd1;
                                    end
                                end
                                else
                                begin
                                    fast_steps_reg <= fast_steps_reg + 5'd1;
                                end
                                x_reg         <= q_cmd.value;
                                stg_reg       <= '0;
                                pend_reg      <= 1'b0;
                                iss_reg       <= '0;
                                chk_valid_reg <= 1'b0;
                                state_reg     <= cfg.direction ? S_INV : S_FWD;
                            end
                            CMD_PASS:
                            begin
                                res_reg   <= q_cmd.raw;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_FWD:
                begin
                    // one table read per cycle, each fed by the previous read
                    if (stg_reg == 4'(NUM_STAGES))
                    begin
                        res_reg   <= 8'(rd_data_reg) + 8'(LETTER_BASE);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        stg_reg  <= stg_reg + 4'd1;
                        pend_reg <= 1'b1;
                    end
                end
                S_INV:
                begin
                    // probe rotated positions in order until the first match or the last one
                    if (inv_match || inv_last)
                    begin
                        if (stg_reg == 4'(NUM_STAGES - 1))
                        begin
                            res_reg   <= 8'(inv_x) + 8'(LETTER_BASE);
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            x_reg         <= inv_x;
                            stg_reg       <= stg_reg + 4'd1;
                            iss_reg       <= '0;
                            chk_valid_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        chk_valid_reg <= 1'b1;
                        chk_k_reg     <= iss_reg;
                        iss_reg       <= iss_reg + 5'd1;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        char_out_reg  <= res_reg;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    `TRSC_ASSERT_NOW(a_offsets_range, 1'b1, (off_fast_reg < 5'(ALPHABET)) && (off_middle_reg < 5'(ALPHABET)) && (off_slow_reg < 5'(ALPHABET)), "rotor offset out of range")
    `TRSC_ASSERT_NEXT(a_restart_clears, q_pop && (q_cmd.kind == CMD_RESTART), (fast_steps_reg == '0) && (middle_steps_reg == '0), "restart left step counters set")

endmodule

`default_nettype wire

>>> design/three_rotor_substitution_cipher_top.sv
// Top level of the three-rotor substitution cipher.
// Channels:
//   Input (in_valid/in_ready) carries one transaction per handshake: a table
//   entry load, a rotor restart, or a character to process.
//   Output (out_valid/out_ready) returns one byte per character transaction;
//   loads and restarts return nothing.
//   Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once; the
//   user must make them only while the block is idle; the block does not enforce it.
// Sequencing (back end, one transaction at a time):
//   Loads and restarts complete in the idle state; non-letters go to output staging.
//   An encrypted letter takes a rotor step, 9 chained reads of the
//   wiring memory, and output staging.
//   A decrypted letter searches each of the 9 chain steps for the first
//   matching entry, one read per cycle. A short queue decouples input from
//   this sequencer.
// Reset: rotor offsets, step counters and registers clear; wiring tables hold
//   garbage until loaded.
// Stall: a result waits in the output register; the queue keeps taking input
//   until it fills, then in_ready drops.
`default_nettype none

module three_rotor_substitution_cipher_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [2:0] table_select,
    input  logic [4:0] entry_index,
    input  logic [4:0] entry_value,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] char_out
);
    import trsc_pkg::*;

    cfg_t cfg_reg;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DIRECTION:    cfg_reg.direction    <= cfg_data[0];
                REG_START_FAST:   cfg_reg.start_fast   <= cfg_data;
                REG_START_MIDDLE: cfg_reg.start_middle <= cfg_data;
                REG_START_SLOW:   cfg_reg.start_slow   <= cfg_data;
            endcase
        end
    end

    trsc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .table_select (table_select),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .char_in      (char_in),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop)
    );

    trsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_out  (char_out)
    );

endmodule

`default_nettype wire
